// ===== hdl/psc_pkg.sv =====
// shared types and constants of the point source colour field
`default_nettype none
package psc_pkg;
    localparam int COORD_W = 24;
    localparam int COLOR_W = 8;
    localparam int COUNT_W = 4;
    localparam int LIMIT_W = 23;
    localparam int ELAPSED_W = 16;
    localparam int D2_W = 50;
    localparam int WEIGHT_W = 17;
    localparam int SUM_W = 28;
    localparam int INT_W = SUM_W - 16;
    localparam int CFG_DATA_W = 23;
    localparam int CFG_INDEX_W = 2;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_SHADE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_POINT_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BOUNCE_LIMIT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_LEVEL = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] vel_x;
        logic signed [COORD_W-1:0] vel_y;
        logic [COORD_W-1:0]        falloff;
        logic [COLOR_W-1:0]        red;
        logic [COLOR_W-1:0]        green;
        logic [COLOR_W-1:0]        blue;
    } entry_t;

    typedef struct packed {
        logic                start;
        logic [COORD_W-1:0]  falloff;
        logic [D2_W-1:0]     d2;
    } wdiv_ctrl_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] quotient;
    } wdiv_stat_t;
endpackage
`default_nettype wire

// ===== hdl/psc_if.sv =====
// channel interfaces for input and result transactions
`default_nettype none
interface psc_in_if;
    logic                valid;
    logic                ready;
    logic [1:0]          mode;
    logic [2:0]          index;
    logic signed [23:0]  coord_x;
    logic signed [23:0]  coord_y;
    logic signed [23:0]  vel_x;
    logic signed [23:0]  vel_y;
    logic [23:0]         radius;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [15:0]         elapsed;
    modport source (output valid, mode, index, coord_x, coord_y, vel_x, vel_y, radius,
                    red, green, blue, elapsed, input ready);
    modport sink (input valid, mode, index, coord_x, coord_y, vel_x, vel_y, radius,
                  red, green, blue, elapsed, output ready);
endinterface

interface psc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface
`default_nettype wire

// ===== hdl/psc_cell.sv =====
// one storage cell of the rotating point table
`default_nettype none
module psc_cell (
    input  wire logic           clk,
    input  wire logic           shift,
    input  wire psc_pkg::entry_t d,
    output psc_pkg::entry_t      q
);
    import psc_pkg::*;

    entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;
endmodule
`default_nettype wire

// ===== hdl/psc_wdiv.sv =====
// serial restoring divider for the falloff weight, one quotient bit per cycle
`default_nettype none
module psc_wdiv (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire psc_pkg::wdiv_ctrl_t ctrl,
    output psc_pkg::wdiv_stat_t      stat
);
    import psc_pkg::*;

    logic [D2_W:0]   rem_reg;
    logic [D2_W-1:0] den_reg;
    logic [15:0]     q_reg;
    logic [3:0]      cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [D2_W:0]   trial;
    logic            ge;

    assign trial = {rem_reg[D2_W-1:0], 1'b0};
    assign ge = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 4'd15);
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg <= {{(D2_W + 1 - COORD_W - 16){1'b0}}, ctrl.falloff, 16'd0};
            den_reg <= ctrl.d2;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (trial - {1'b0, den_reg}) : trial;
            q_reg <= {q_reg[14:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.quotient = q_reg;
endmodule
`default_nettype wire

// ===== hdl/point_source_color_field.sv =====
// point source colour field: rotating table of point cells with a shared shading unit
//
// in_ch carries load, tick and shade transactions, out_ch one colour per shade
// transaction; cfg_we/cfg_index/cfg_data write point_count, bounce_limit and
// base_level, which the user must do only while the block is idle (not enforced).
// one transaction is handled at a time; in_ch.ready is high while idle.
// the point table is a ring of NUM_POINTS cells that turns once per load, tick
// and shade transaction; an unused mode is accepted without turning the ring.
// shade stops at each active point to square and sum its distance terms and weigh
// its colour, by the serial weight divider if it lies outside its falloff; then
// each channel is divided by the point count and the result is registered.
// a finished colour waits in the output register; while the receiver stalls
// the block still accepts load and tick transactions, and a later shade
// holds before its result until the register is free.
// reset clears control and config registers (count 4, limit 38400, base 128);
// the table contents are undefined until loaded.
`default_nettype none
module point_source_color_field #(
    parameter int NUM_POINTS = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    psc_in_if.sink                                in_ch,
    psc_out_if.source                             out_ch,
    input  wire logic                             cfg_we,
    input  wire logic [psc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [psc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import psc_pkg::*;

    localparam int K_W = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_ROT  = 8'b0000_0010,
        S_SQ   = 8'b0000_0100,
        S_D2   = 8'b0000_1000,
        S_DIV  = 8'b0001_0000,
        S_ACC  = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    logic [K_W-1:0]       k_reg;
    logic [1:0]           op_reg;
    logic [2:0]           idx_reg;
    entry_t               load_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [LIMIT_W-1:0]   limit_reg;
    logic [COLOR_W-1:0]   base_reg;
    logic [D2_W-2:0]      sqx_reg, sqy_reg;
    logic [WEIGHT_W-1:0]  w_reg;
    logic [SUM_W-1:0]     sum_reg [3];
    logic [INT_W-1:0]     quot_reg [3];
    logic [COUNT_W:0]     crem_reg [3];
    logic [3:0]           cdiv_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_reg [3];

    entry_t cell_q [NUM_POINTS];
    entry_t head, head_next, moved;
    logic   shift;
    logic   last;
    logic   active;
    logic [COUNT_W-1:0] n_act, n_div;
    logic signed [40:0] mx, my;
    logic [COORD_W-1:0] px, py;
    logic signed [COORD_W:0] dx, dy;
    logic [D2_W-1:0]    d2;
    logic               near;
    logic [7:0]         color [3];
    wdiv_ctrl_t wctrl;
    wdiv_stat_t wstat;

    assign head = cell_q[0];
    assign last = (int'(k_reg) == NUM_POINTS - 1);
    assign n_act = (int'(count_reg) < NUM_POINTS) ? count_reg : COUNT_W'(NUM_POINTS);
    assign n_div = (n_act == '0) ? COUNT_W'(1) : n_act;
    assign active = (int'(k_reg) < int'(n_act));

    // tick update of the head entry
    always_comb
    begin
        mx = head.vel_x * $signed({1'b0, elapsed_reg});
        my = head.vel_y * $signed({1'b0, elapsed_reg});
        px = head.pos_x + mx[39:16];
        py = head.pos_y + my[39:16];
        moved = head;
        moved.pos_x = px;
        moved.pos_y = py;
        if (px[23] || (px[22:0] >= limit_reg))
        begin
            moved.vel_x = -head.vel_x;
        end
        if (py[23] || (py[22:0] >= limit_reg))
        begin
            moved.vel_y = -head.vel_y;
        end
    end

    always_comb
    begin
        head_next = head;
        case (op_reg)
            MODE_LOAD:
            begin
                if (int'(k_reg) == int'(idx_reg))
                begin
                    head_next = load_reg;
                end
            end
            MODE_TICK:
            begin
                if (active)
                begin
                    head_next = moved;
                end
            end
            default:
            begin
                head_next = head;
            end
        endcase
    end

    assign shift = ((state_reg == S_ROT) && !((op_reg == MODE_SHADE) && active))
                   || (state_reg == S_ACC);

    generate
        for (genvar i = 0; i < NUM_POINTS; i++)
        begin : g_cell
            entry_t d;
            if (i == NUM_POINTS - 1)
            begin : g_tail
                assign d = head_next;
            end
            else
            begin : g_link
                assign d = cell_q[i + 1];
            end
            psc_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .d     (d),
                .q     (cell_q[i])
            );
        end
    endgenerate

    // distance terms against the sample held in load_reg
    assign dx = {load_reg.pos_x[23], load_reg.pos_x} - {head.pos_x[23], head.pos_x};
    assign dy = {load_reg.pos_y[23], load_reg.pos_y} - {head.pos_y[23], head.pos_y};
    assign d2 = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign near = d2 <= {10'd0, head.falloff, 16'd0};
    assign color[0] = head.red;
    assign color[1] = head.green;
    assign color[2] = head.blue;

    assign wctrl.start = (state_reg == S_D2) && !near;
    assign wctrl.falloff = head.falloff;
    assign wctrl.d2 = d2;

    psc_wdiv u_wdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (wctrl),
        .stat  (wstat)
    );

    assign in_ch.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg <= '0;
            op_reg <= MODE_LOAD;
            out_valid_reg <= 1'b0;
            cdiv_reg <= '0;
            count_reg <= COUNT_W'(4);
            limit_reg <= LIMIT_W'(38400);
            base_reg <= COLOR_W'(128);
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_POINT_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                    REG_BOUNCE_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                    REG_BASE_LEVEL: base_reg <= cfg_data[COLOR_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == S_OUT && (!out_valid_reg || out_ch.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            if (shift)
            begin
                k_reg <= last ? '0 : k_reg + K_W'(1);
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        op_reg <= in_ch.mode;
                        if (in_ch.mode == MODE_LOAD || in_ch.mode == MODE_TICK
                            || in_ch.mode == MODE_SHADE)
                        begin
                            state_reg <= S_ROT;
                        end
                    end
                end
                S_ROT:
                begin
                    if ((op_reg == MODE_SHADE) && active)
                    begin
                        state_reg <= S_SQ;
                    end
                    else if (last)
                    begin
                        state_reg <= (op_reg == MODE_SHADE) ? S_FIN : S_IDLE;
                        cdiv_reg <= '0;
                    end
                end
                S_SQ: state_reg <= S_D2;
                S_D2: state_reg <= near ? S_ACC : S_DIV;
                S_DIV:
                begin
                    if (wstat.done)
                    begin
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    state_reg <= last ? S_FIN : S_ROT;
                    cdiv_reg <= '0;
                end
                S_FIN:
                begin
                    cdiv_reg <= cdiv_reg + 4'd1;
                    if (int'(cdiv_reg) == INT_W - 1)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_ch.valid)
        begin
            idx_reg <= in_ch.index;
            elapsed_reg <= in_ch.elapsed;
            load_reg.pos_x <= in_ch.coord_x;
            load_reg.pos_y <= in_ch.coord_y;
            load_reg.vel_x <= in_ch.vel_x;
            load_reg.vel_y <= in_ch.vel_y;
            load_reg.falloff <= in_ch.radius;
            load_reg.red <= in_ch.red;
            load_reg.green <= in_ch.green;
            load_reg.blue <= in_ch.blue;
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= {{(SUM_W - 24){1'b0}}, base_reg, 16'd0};
            end
        end
        if (state_reg == S_SQ)
        begin
            sqx_reg <= (D2_W-1)'(dx * dx);
            sqy_reg <= (D2_W-1)'(dy * dy);
        end
        if (state_reg == S_D2 && near)
        begin
            w_reg <= WEIGHT_W'(65536);
        end
        if (state_reg == S_DIV && wstat.done)
        begin
            w_reg <= {1'b0, wstat.quotient};
        end
        if (state_reg == S_ACC)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= sum_reg[c] + SUM_W'(color[c] * w_reg);
            end
        end
        if ((state_reg == S_ROT && last && !((op_reg == MODE_SHADE) && active))
            || (state_reg == S_ACC && last))
        begin
            for (int c = 0; c < 3; c++)
            begin
                crem_reg[c] <= '0;
            end
        end
        if (state_reg == S_FIN)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (cdiv_reg == '0)
                begin
                    if ({4'd0, sum_reg[c][SUM_W-1]} >= {1'b0, n_div})
                    begin
                        crem_reg[c] <= 5'd1 - {1'b0, n_div};
                        quot_reg[c] <= {sum_reg[c][SUM_W-2:16], 1'b1};
                    end
                    else
                    begin
                        crem_reg[c] <= {4'd0, sum_reg[c][SUM_W-1]};
                        quot_reg[c] <= {sum_reg[c][SUM_W-2:16], 1'b0};
                    end
                end
                else
                begin
                    if ({crem_reg[c][COUNT_W-1:0], quot_reg[c][INT_W-1]} >= {1'b0, n_div})
                    begin
                        crem_reg[c] <= {crem_reg[c][COUNT_W-1:0], quot_reg[c][INT_W-1]}
                                       - {1'b0, n_div};
                        quot_reg[c] <= {quot_reg[c][INT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        crem_reg[c] <= {crem_reg[c][COUNT_W-1:0], quot_reg[c][INT_W-1]};
                        quot_reg[c] <= {quot_reg[c][INT_W-2:0], 1'b0};
                    end
                end
            end
        end
        if (state_reg == S_OUT && (!out_valid_reg || out_ch.ready))
        begin
            for (int c = 0; c < 3; c++)
            begin
                out_reg[c] <= (quot_reg[c] > INT_W'(255)) ? 8'd255 : quot_reg[c][7:0];
            end
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.out_red = out_reg[0];
    assign out_ch.out_green = out_reg[1];
    assign out_ch.out_blue = out_reg[2];

`ifndef NO_ASSERTIONS
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(k_reg) < NUM_POINTS)
        else $error("ring position out of range");
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        wstat.done |-> state_reg == S_DIV)
        else $error("weight divider finished outside its state");
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wstat.busy |-> state_reg == S_DIV)
        else $error("weight divider running outside its state");
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised without a shade transaction");
    a_k_home: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (k_reg == '0))
        else $error("ring not aligned while idle");
`endif
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// testbench for point_source_color_field: directed table, then random phases
`timescale 1ns / 100ps
module tb;
    import psc_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int TABLE_DEPTH = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES = 2000;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef longint unsigned u64_t;

    typedef struct {
        logic [1:0]         mode;
        logic [2:0]         index;
        logic signed [23:0] cx;
        logic signed [23:0] cy;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic [23:0]        radius;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [15:0]        elapsed;
        bit                 typed;
        logic [7:0]         exp_red;
        logic [7:0]         exp_green;
        logic [7:0]         exp_blue;
    } txn_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } colour_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    always #1 clk = ~clk;

    psc_in_if in_ch();
    psc_out_if out_ch();

    point_source_color_field dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // own copy of the point table and registers
    logic signed [23:0] pos_x[TABLE_DEPTH];
    logic signed [23:0] pos_y[TABLE_DEPTH];
    logic signed [23:0] vel_x[TABLE_DEPTH];
    logic signed [23:0] vel_y[TABLE_DEPTH];
    logic [23:0]        falloff[TABLE_DEPTH];
    logic [7:0]         col_r[TABLE_DEPTH];
    logic [7:0]         col_g[TABLE_DEPTH];
    logic [7:0]         col_b[TABLE_DEPTH];
    logic [3:0]         count_reg;
    logic [22:0]        limit_reg;
    logic [7:0]         base_reg;

    colour_t expected_colours[$];
    txn_t    directed_rows[$];
    int      fails = 0;
    int      shades_seen = 0;
    int      loads_sent = 0;
    int      ticks_sent = 0;
    int      settings_run = 0;
    bit      calm = 1'b0;
    int      hold_left = 0;
    longint  cycles = 0;

    function automatic int unsigned live_points();
        return (count_reg < TABLE_DEPTH) ? count_reg : TABLE_DEPTH;
    endfunction

    function automatic void move_axis(input logic signed [23:0] pos,
                                      input logic signed [23:0] vel,
                                      input logic [15:0] el,
                                      output logic signed [23:0] npos,
                                      output logic signed [23:0] nvel);
        longint step;
        step = (longint'(vel) * longint'({1'b0, el})) >>> 16;
        npos = pos + step[23:0];
        nvel = vel;
        if (npos < 0 || longint'(npos) >= longint'({1'b0, limit_reg}))
            nvel = -vel;
    endfunction

    function automatic void move_points(input logic [15:0] el);
        for (int i = 0; i < live_points(); i++)
        begin
            move_axis(pos_x[i], vel_x[i], el, pos_x[i], vel_x[i]);
            move_axis(pos_y[i], vel_y[i], el, pos_y[i], vel_y[i]);
        end
    endfunction

    function automatic colour_t shade_colour(input logic signed [23:0] sx,
                                             input logic signed [23:0] sy);
        u64_t sum_r, sum_g, sum_b, d2, w, divisor;
        longint dx, dy;
        int unsigned n;
        colour_t c;
        n = live_points();
        sum_r = u64_t'(base_reg) << 16;
        sum_g = sum_r;
        sum_b = sum_r;
        for (int i = 0; i < n; i++)
        begin
            dx = longint'(sx) - longint'(pos_x[i]);
            dy = longint'(sy) - longint'(pos_y[i]);
            d2 = u64_t'(dx * dx) + u64_t'(dy * dy);
            if (d2 <= (u64_t'(falloff[i]) << 16))
                w = 65536;
            else
                w = (u64_t'(falloff[i]) << 32) / d2;
            sum_r += u64_t'(col_r[i]) * w;
            sum_g += u64_t'(col_g[i]) * w;
            sum_b += u64_t'(col_b[i]) * w;
        end
        divisor = u64_t'((n == 0) ? 1 : n) << 16;
        sum_r = sum_r / divisor;
        sum_g = sum_g / divisor;
        sum_b = sum_b / divisor;
        c.red = (sum_r > 255) ? 8'd255 : sum_r[7:0];
        c.green = (sum_g > 255) ? 8'd255 : sum_g[7:0];
        c.blue = (sum_b > 255) ? 8'd255 : sum_b[7:0];
        return c;
    endfunction

    function automatic void predict(input txn_t t);
        colour_t c;
        case (t.mode)
            MODE_LOAD:
            begin
                pos_x[t.index] = t.cx;
                pos_y[t.index] = t.cy;
                vel_x[t.index] = t.vx;
                vel_y[t.index] = t.vy;
                falloff[t.index] = t.radius;
                col_r[t.index] = t.red;
                col_g[t.index] = t.green;
                col_b[t.index] = t.blue;
                loads_sent++;
            end
            MODE_TICK:
            begin
                move_points(t.elapsed);
                ticks_sent++;
            end
            MODE_SHADE:
            begin
                if (t.typed)
                begin
                    c.red = t.exp_red;
                    c.green = t.exp_green;
                    c.blue = t.exp_blue;
                end
                else
                    c = shade_colour(t.cx, t.cy);
                expected_colours.push_back(c);
            end
            default: ;
        endcase
    endfunction

    function automatic txn_t blank_txn(input logic [1:0] mode);
        txn_t t;
        t = '{mode: mode, index: 3'd0, cx: 24'sd0, cy: 24'sd0, vx: 24'sd0, vy: 24'sd0,
              radius: 24'd1, red: 8'd0, green: 8'd0, blue: 8'd0, elapsed: 16'd0,
              typed: 1'b0, exp_red: 8'd0, exp_green: 8'd0, exp_blue: 8'd0};
        return t;
    endfunction

    function automatic logic signed [23:0] rand_coord();
        if ($urandom_range(3) == 0)
            return 24'($urandom());
        return $signed(24'($urandom_range(44000))) - 24'sd2000;
    endfunction

    function automatic logic signed [23:0] rand_vel();
        if ($urandom_range(4) == 0)
            return 24'($urandom());
        return $signed(24'($urandom_range(40000))) - 24'sd20000;
    endfunction

    function automatic txn_t rand_txn();
        txn_t t;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 25)
            t = blank_txn(MODE_LOAD);
        else if (pick < 45)
            t = blank_txn(MODE_TICK);
        else if (pick < 95)
            t = blank_txn(MODE_SHADE);
        else
            t = blank_txn(MODE_SPARE);
        t.index = 3'($urandom_range(7));
        t.cx = rand_coord();
        t.cy = rand_coord();
        t.vx = rand_vel();
        t.vy = rand_vel();
        case ($urandom_range(5))
            0: t.radius = 24'($urandom());
            1: t.radius = 24'd0;
            default: t.radius = 24'($urandom_range(30000));
        endcase
        t.red = 8'($urandom());
        t.green = 8'($urandom());
        t.blue = 8'($urandom());
        t.elapsed = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(4000));
        return t;
    endfunction

    function automatic void add_load(input logic [2:0] idx, input logic signed [23:0] x,
                                     input logic signed [23:0] y,
                                     input logic signed [23:0] vx,
                                     input logic signed [23:0] vy, input logic [23:0] rad,
                                     input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b);
        txn_t t;
        t = blank_txn(MODE_LOAD);
        t.index = idx;
        t.cx = x;
        t.cy = y;
        t.vx = vx;
        t.vy = vy;
        t.radius = rad;
        t.red = r;
        t.green = g;
        t.blue = b;
        directed_rows.push_back(t);
    endfunction

    function automatic void add_shade(input logic signed [23:0] x,
                                      input logic signed [23:0] y, input bit typed,
                                      input logic [7:0] ev);
        txn_t t;
        t = blank_txn(MODE_SHADE);
        t.cx = x;
        t.cy = y;
        t.typed = typed;
        t.exp_red = ev;
        t.exp_green = ev;
        t.exp_blue = ev;
        directed_rows.push_back(t);
    endfunction

    function automatic void add_tick(input logic [15:0] el);
        txn_t t;
        t = blank_txn(MODE_TICK);
        t.elapsed = el;
        directed_rows.push_back(t);
    endfunction

    task automatic send(input txn_t t);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 14)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.mode <= t.mode;
        in_ch.index <= t.index;
        in_ch.coord_x <= t.cx;
        in_ch.coord_y <= t.cy;
        in_ch.vel_x <= t.vx;
        in_ch.vel_y <= t.vy;
        in_ch.radius <= t.radius;
        in_ch.red <= t.red;
        in_ch.green <= t.green;
        in_ch.blue <= t.blue;
        in_ch.elapsed <= t.elapsed;
        in_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict(t);
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_colours.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_POINT_COUNT: count_reg = data[3:0];
            REG_BOUNCE_LIMIT: limit_reg = data[22:0];
            REG_BASE_LEVEL: base_reg = data[7:0];
            default: ;
        endcase
    endtask

    // receiver side
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left--;
        end
        else
            out_ch.ready <= calm || ($urandom_range(99) >= 14);
    end

    always @(posedge clk)
    begin
        colour_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            shades_seen++;
            if (expected_colours.size() == 0)
            begin
                $display("%0t: unexpected colour r=%0d g=%0d b=%0d", $time,
                         out_ch.out_red, out_ch.out_green, out_ch.out_blue);
                fails++;
            end
            else
            begin
                e = expected_colours.pop_front();
                if (out_ch.out_red !== e.red)
                begin
                    $display("%0t: red expected %0d actual %0d", $time, e.red,
                             out_ch.out_red);
                    fails++;
                end
                if (out_ch.out_green !== e.green)
                begin
                    $display("%0t: green expected %0d actual %0d", $time, e.green,
                             out_ch.out_green);
                    fails++;
                end
                if (out_ch.out_blue !== e.blue)
                begin
                    $display("%0t: blue expected %0d actual %0d", $time, e.blue,
                             out_ch.out_blue);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        logic [3:0]  counts[6];
        logic [22:0] limits[6];
        logic [7:0]  bases[6];
        in_ch.valid = 1'b0;
        in_ch.mode = MODE_LOAD;
        in_ch.index = '0;
        in_ch.coord_x = '0;
        in_ch.coord_y = '0;
        in_ch.vel_x = '0;
        in_ch.vel_y = '0;
        in_ch.radius = '0;
        in_ch.red = '0;
        in_ch.green = '0;
        in_ch.blue = '0;
        in_ch.elapsed = '0;
        out_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_POINT_COUNT;
        cfg_data = '0;
        count_reg = 4'd4;
        limit_reg = 23'd38400;
        base_reg = 8'd128;

        counts = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd5, 4'd3};
        limits = '{23'd38400, 23'd0, 23'h7FFFFF, 23'd1000, 23'd20000, 23'd38400};
        bases = '{8'd128, 8'd0, 8'd255, 8'd77, 8'd10, 8'd200};

        // black points at reset settings: channel is base over count
        for (int i = 0; i < TABLE_DEPTH; i++)
            add_load(3'(i), 24'(256 * i), 24'(512 * i), 24'sd100, -24'sd100, 24'd1,
                     8'd0, 8'd0, 8'd0);
        add_shade(24'sd0, 24'sd0, 1'b1, 8'd32);
        directed_rows.push_back(blank_txn(MODE_SPARE));
        // full colour on the sample point saturates
        add_load(3'd0, 24'sd0, 24'sd0, -24'sd8388608, 24'sd8388607, 24'hFFFFFF,
                 8'd255, 8'd255, 8'd255);
        add_load(3'd1, 24'sd0, 24'sd0, 24'sd8388607, -24'sd8388608, 24'hFFFFFF,
                 8'd255, 8'd255, 8'd255);
        add_load(3'd2, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 24'hFFFFFF, 8'd255, 8'd255, 8'd255);
        add_load(3'd3, 24'sd0, 24'sd0, 24'sd256, -24'sd256, 24'hFFFFFF,
                 8'd255, 8'd255, 8'd255);
        add_shade(24'sd0, 24'sd0, 1'b1, 8'd255);
        add_tick(16'hFFFF);
        add_tick(16'd0);
        add_load(3'd4, 24'sd8388607, -24'sd8388608, 24'sd0, 24'sd0, 24'd0,
                 8'd255, 8'd0, 8'd128);
        add_shade(24'sd8388607, -24'sd8388608, 1'b0, 8'd0);
        add_shade(-24'sd8388608, 24'sd8388607, 1'b0, 8'd0);
        add_tick(16'd1);
        add_shade(24'sd100, 24'sd100, 1'b0, 8'd0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send(directed_rows[i]);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_POINT_COUNT, counts[p]);
            write_reg(REG_BOUNCE_LIMIT, limits[p]);
            write_reg(REG_BASE_LEVEL, bases[p]);
            calm = (p == 1);
            settings_run++;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // long receiver stall so the output register fills
                if (p == 3 && k == 20)
                    hold_left = HOLD_CYCLES;
                send(rand_txn());
            end
            calm = 1'b0;
            drain();
        end

        $display("covered %0d loads, %0d ticks and %0d shaded colours", loads_sent,
                 ticks_sent, shades_seen);
        $display("over %0d register settings, with a long output stall", settings_run + 1);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
